FILE: design/graph_reachability_query_macros.svh
// ----------------------------------------------------------------------------
// Graph reachability query assertion macros
// Shared property wrappers for the synchronous checks of the design.
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_QUERY_MACROS_SVH
`define GRAPH_REACHABILITY_QUERY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/grq_pkg.sv
// ----------------------------------------------------------------------------
// Graph reachability query package
// Request codes and the shared type of the pending-node picker.
// ----------------------------------------------------------------------------
package grq_pkg;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // The walk looks at the pending set one group of this many nodes at a time.
  localparam int PICK_W   = 8;
  localparam int PICK_IDX = 3;

  typedef struct packed {
    logic                found;
    logic [PICK_IDX-1:0] idx;
  } pick_t;

endpackage

FILE: design/grq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grq_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/grq_pick.sv
// ----------------------------------------------------------------------------
// Pending-node picker
// Finds the lowest set bit in one group of the pending node set.
// ----------------------------------------------------------------------------
module grq_pick (
  input  logic [grq_pkg::PICK_W-1:0] bits,
  output grq_pkg::pick_t             res
);

  always_comb begin
    res.found = |bits;
    res.idx   = '0;
    for (int i = grq_pkg::PICK_W - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.idx = grq_pkg::PICK_IDX'(i);
      end
    end
  end

endmodule

FILE: design/graph_reachability_query.sv
// ----------------------------------------------------------------------------
// Graph reachability query
// Directed graph stored as one adjacency row per node; answers reachability
// by expanding nodes one at a time from a pending set.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | fields
//   --------+--------------------+-------------------------------------
//   request | in_valid/in_ready  | req_type, src_node, dst_node
//   result  | out_valid/out_ready| reachable, source_known
//
// Add edge writes the updated source row in S_EDGE; clear completes in idle, and
// a query that needs no walk goes straight to S_DONE. A walk expands one picked
// node at a time via the single adjacency RAM read port, passing empty 8-bit groups.
// Reset and clear take effect at once: a row whose node has no outgoing flag
// reads as empty, so no clearing pass is needed.
// The block takes a new request only when idle, and a finished result waits
// in its final state until the output register is free.

module graph_reachability_query #(
  parameter int NODE_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] src_node,
  input  logic [7:0] dst_node,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       reachable,
  output logic       source_known
);

  `include "graph_reachability_query_macros.svh"

  localparam int N    = 1 << NODE_BITS;
  localparam int CW   = grq_pkg::PICK_W;
  localparam int CHB  = NODE_BITS - grq_pkg::PICK_IDX;
  localparam int NCH  = N / CW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EDGE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_EXPAND = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state;
  logic [N-1:0]         has_out;
  logic [N-1:0]         visited;
  logic [N-1:0]         pending;
  logic [CHB-1:0]       chunk;
  logic [CHB-1:0]       empty_cnt;
  logic                 cur_known;
  logic [NODE_BITS-1:0] q_src;
  logic [NODE_BITS-1:0] q_dst;
  logic                 res_reach;
  logic                 res_known;

  logic [NODE_BITS-1:0] src_n;
  logic [NODE_BITS-1:0] dst_n;
  logic [NODE_BITS-1:0] scan_node;
  logic [NODE_BITS-1:0] rd_addr;
  logic [N-1:0]         rd_data;
  logic [N-1:0]         wr_data;
  logic                 wr_en;
  logic [N-1:0]         cand;
  logic [CW-1:0]        group_bits;
  grq_pkg::pick_t       pick;

  assign src_n = NODE_BITS'(src_node);
  assign dst_n = NODE_BITS'(dst_node);

  assign group_bits = pending[chunk*CW +: CW];
  assign scan_node  = {chunk, pick.idx};

  assign in_ready = (state == S_IDLE);
  assign rd_addr  = (state == S_IDLE) ? src_n : scan_node;
  assign wr_en    = (state == S_EDGE);
  assign wr_data  = (rd_data & {N{has_out[q_src]}}) | (N'(1) << q_dst);
  assign cand     = rd_data & {N{cur_known}} & ~visited;

  grq_pick u_pick (
    .bits (group_bits),
    .res  (pick)
  );

  grq_ram #(
    .WIDTH (N),
    .DEPTH (N)
  ) u_adj_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_src),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      has_out   <= '0;
      out_valid <= 1'b0;
    end else begin
      // A result leaving in the same cycle as the next one loads is handled below.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_src <= src_n;
            q_dst <= dst_n;
            unique case (req_type)
              grq_pkg::REQ_ADD: begin
                state <= S_EDGE;
              end
              grq_pkg::REQ_CLEAR: begin
                has_out <= '0;
              end
              grq_pkg::REQ_QUERY: begin
                res_known <= has_out[src_n];
                res_reach <= has_out[src_n];
                if (!has_out[src_n] || (src_n == dst_n)) begin
                  state <= S_DONE;
                end else begin
                  visited   <= N'(1) << src_n;
                  pending   <= N'(1) << src_n;
                  chunk     <= '0;
                  empty_cnt <= '0;
                  state     <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_EDGE: begin
          has_out[q_src] <= 1'b1;
          state          <= S_IDLE;
        end
        S_SCAN: begin
          if (pick.found) begin
            pending[scan_node] <= 1'b0;
            cur_known          <= has_out[scan_node];
            empty_cnt          <= '0;
            state              <= S_EXPAND;
          end else if (empty_cnt == CHB'(NCH - 1)) begin
            // Every group came up empty in a row: nothing left to expand.
            res_reach <= 1'b0;
            state     <= S_DONE;
          end else begin
            empty_cnt <= empty_cnt + 1'b1;
            chunk     <= chunk + 1'b1;
          end
        end
        S_EXPAND: begin
          if (cand[q_dst]) begin
            res_reach <= 1'b1;
            state     <= S_DONE;
          end else begin
            visited <= visited | cand;
            pending <= pending | cand;
            state   <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            reachable    <= res_reach;
            source_known <= res_known;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GRQ_ASSERT_NEXT(a_pick_expands, clk, rst, (state == S_SCAN) && pick.found, state == S_EXPAND, "picked node not expanded")
  `GRQ_ASSERT_SAME(a_reach_known, clk, rst, out_valid && reachable, source_known, "reachable without known source")
  `GRQ_ASSERT_SAME(a_pending_visited, clk, rst, state == S_SCAN, (pending & ~visited) == '0, "pending node not visited")
  `GRQ_ASSERT_NEXT(a_visited_grows, clk, rst, state == S_EXPAND, (visited & $past(visited)) == $past(visited), "visited set lost a node")

endmodule
